/* rtl/alfm_pkg.sv */
`timescale 1ns / 1ps

package alfm_pkg;

  localparam int STATUS_BITS    = 3;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int LIMIT_BITS     = 16;

  typedef enum logic [STATUS_BITS-1:0] {
    MODE_NORMAL    = 3'd0,
    MODE_OVER      = 3'd1,
    MODE_UNDER     = 3'd2,
    MODE_STUCK     = 3'd3,
    MODE_ACK_OVER  = 3'd4,
    MODE_ACK_UNDER = 3'd5,
    MODE_ACK_STUCK = 3'd6
  } mode_t;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_ACK    = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_OVERLOAD  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNDERLOAD = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOLERANCE = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STUCK_LIM = 3'd3;

  localparam logic [LIMIT_BITS-1:0] STUCK_LIMIT_RESET = 16'd1000;

endpackage

/* rtl/alfm_step.sv */
`timescale 1ns / 1ps

module alfm_step #(
  parameter int SAMPLE_BITS = 10,
  parameter int COUNT_BITS  = 16
) (
  input  logic                         opcode,
  input  logic [SAMPLE_BITS-1:0]       sample,
  input  alfm_pkg::mode_t              mode,
  input  logic [COUNT_BITS-1:0]        stable_count,
  input  logic [SAMPLE_BITS-1:0]       reference_level,
  input  logic                         event_pending,
  input  logic [SAMPLE_BITS-1:0]       overload_level,
  input  logic [SAMPLE_BITS-1:0]       underload_level,
  input  logic [SAMPLE_BITS-1:0]       tolerance,
  input  logic [alfm_pkg::LIMIT_BITS-1:0] stuck_limit,
  output alfm_pkg::mode_t              mode_next,
  output logic [COUNT_BITS-1:0]        stable_count_next,
  output logic [SAMPLE_BITS-1:0]       reference_level_next,
  output logic                         event_pending_next
);
  import alfm_pkg::*;

  localparam int WIN_BITS = SAMPLE_BITS + 2;
  localparam int CMP_BITS = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

  logic signed [WIN_BITS-1:0] s_ext;
  logic signed [WIN_BITS-1:0] win_hi;
  logic signed [WIN_BITS-1:0] win_lo;
  logic                       in_win;
  logic [COUNT_BITS-1:0]      cnt_track;
  logic [SAMPLE_BITS-1:0]     ref_track;
  logic                       stuck_track;

  assign s_ext  = $signed({2'b00, sample});
  assign win_hi = $signed({2'b00, reference_level}) + $signed({2'b00, tolerance});
  assign win_lo = $signed({2'b00, reference_level}) - $signed({2'b00, tolerance});
  assign in_win = (s_ext <= win_hi) && (s_ext >= win_lo);

  always_comb begin
    if (in_win) begin
      cnt_track = (stable_count == '1) ? stable_count : stable_count + 1'b1;
      ref_track = reference_level;
    end else begin
      cnt_track = '0;
      ref_track = sample;
    end
  end

  assign stuck_track = CMP_BITS'(cnt_track) > CMP_BITS'(stuck_limit);

  always_comb begin
    mode_next            = mode;
    stable_count_next    = stable_count;
    reference_level_next = reference_level;
    event_pending_next   = event_pending;
    case (opcode)
      OP_SAMPLE: begin
        case (mode)
          MODE_NORMAL: begin
            stable_count_next    = cnt_track;
            reference_level_next = ref_track;
            if (sample > overload_level) begin
              mode_next          = MODE_OVER;
              event_pending_next = 1'b1;
            end
            if (sample < underload_level) begin
              mode_next          = MODE_UNDER;
              event_pending_next = 1'b1;
            end
            if (stuck_track) begin
              mode_next          = MODE_STUCK;
              event_pending_next = 1'b1;
            end
          end
          MODE_ACK_OVER: begin
            if (sample < overload_level) begin
              mode_next = MODE_NORMAL;
            end
          end
          MODE_ACK_UNDER: begin
            stable_count_next    = cnt_track;
            reference_level_next = ref_track;
            if (sample > underload_level) begin
              mode_next = MODE_NORMAL;
            end
            if (stuck_track) begin
              mode_next          = MODE_STUCK;
              event_pending_next = 1'b1;
            end
          end
          MODE_ACK_STUCK: begin
            if ((s_ext >= win_hi) || (s_ext <= win_lo)) begin
              mode_next            = MODE_NORMAL;
              stable_count_next    = '0;
              reference_level_next = sample;
            end
          end
          default: begin
          end
        endcase
      end
      OP_ACK: begin
        event_pending_next = 1'b0;
        case (mode)
          MODE_OVER: begin
            mode_next         = MODE_ACK_OVER;
            stable_count_next = '0;
          end
          MODE_UNDER: begin
            mode_next = MODE_ACK_UNDER;
          end
          MODE_STUCK: begin
            mode_next = MODE_ACK_STUCK;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/adc_level_fault_monitor_core.sv */
`timescale 1ns / 1ps
// ADC level fault monitor.
// Input channel (in_valid/in_ready): one word per item, opcode 0 carries a new
// ADC code in sample, opcode 1 acknowledges the current fault.
// Output channel (out_valid/out_ready): one word per input word, giving the
// mode after the item (status), the pending event flag (event_res) and the
// most recent sample code (level).
// Configuration channel (cfg_valid/cfg_ready): cfg_index selects overload
// level (0), underload level (1), tolerance (2) or stuck limit (3); other
// indexes are ignored. Always ready; write only while the block is idle.
// Path from input acceptance to result valid: input register, then the state
// update and result register.
// Throughput: 1 word per cycle unless a result is held; mode, counter and
// reference update is a single compare-and-select pass from the input register.
// Reset: mode normal, counter, reference, event and last sample cleared,
// thresholds back to 1000, 20, 2 and 1000; both pipeline stages empty.
// Stall: a held result keeps the input register full; in_ready drops only
// when both stages hold a word.
module adc_level_fault_monitor_core #(
  parameter int SAMPLE_BITS = 10,
  parameter int COUNT_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                opcode,
  input  logic [SAMPLE_BITS-1:0]              sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [alfm_pkg::STATUS_BITS-1:0]    status,
  output logic                                event_res,
  output logic [SAMPLE_BITS-1:0]              level,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [alfm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [alfm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import alfm_pkg::*;

  logic                   in_full;
  logic                   opcode_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic                   step_go;
  logic                   out_free;

  logic [SAMPLE_BITS-1:0] overload_level;
  logic [SAMPLE_BITS-1:0] underload_level;
  logic [SAMPLE_BITS-1:0] tolerance;
  logic [LIMIT_BITS-1:0]  stuck_limit;

  mode_t                  mode;
  mode_t                  mode_next;
  logic [COUNT_BITS-1:0]  stable_count;
  logic [COUNT_BITS-1:0]  stable_count_next;
  logic [SAMPLE_BITS-1:0] reference_level;
  logic [SAMPLE_BITS-1:0] reference_level_next;
  logic                   event_pending;
  logic                   event_pending_next;
  logic [SAMPLE_BITS-1:0] last_sample;
  logic [SAMPLE_BITS-1:0] last_sample_next;

  assign out_free  = !out_valid || out_ready;
  assign step_go   = in_full && out_free;
  assign in_ready  = !in_full || out_free;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      overload_level  <= SAMPLE_BITS'(1000);
      underload_level <= SAMPLE_BITS'(20);
      tolerance       <= SAMPLE_BITS'(2);
      stuck_limit     <= STUCK_LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OVERLOAD:  overload_level  <= cfg_data[SAMPLE_BITS-1:0];
        REG_UNDERLOAD: underload_level <= cfg_data[SAMPLE_BITS-1:0];
        REG_TOLERANCE: tolerance       <= cfg_data[SAMPLE_BITS-1:0];
        REG_STUCK_LIM: stuck_limit     <= cfg_data[LIMIT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (step_go) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      opcode_r <= opcode;
      sample_r <= sample;
    end
  end

  alfm_step #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_step (
    .opcode               (opcode_r),
    .sample               (sample_r),
    .mode                 (mode),
    .stable_count         (stable_count),
    .reference_level      (reference_level),
    .event_pending        (event_pending),
    .overload_level       (overload_level),
    .underload_level      (underload_level),
    .tolerance            (tolerance),
    .stuck_limit          (stuck_limit),
    .mode_next            (mode_next),
    .stable_count_next    (stable_count_next),
    .reference_level_next (reference_level_next),
    .event_pending_next   (event_pending_next)
  );

  assign last_sample_next = (opcode_r == OP_SAMPLE) ? sample_r : last_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_NORMAL;
      stable_count    <= '0;
      reference_level <= '0;
      event_pending   <= 1'b0;
      last_sample     <= '0;
    end else if (step_go) begin
      mode            <= mode_next;
      stable_count    <= stable_count_next;
      reference_level <= reference_level_next;
      event_pending   <= event_pending_next;
      last_sample     <= last_sample_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      status    <= mode_next;
      event_res <= event_pending_next;
      level     <= last_sample_next;
    end
  end

endmodule
